[src/kuf_pkg.sv]
// Shared types and constants of the Kruskal union-find edge filter.
package kuf_pkg;

   // forest size, derived address width and field widths
   localparam int NODE_COUNT = 1024;
   localparam int ADDR_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int NODE_W     = 10;
   localparam int SLOT_W     = 10;
   localparam int COST_W     = 16;

   // input word: one edge or a clear command
   typedef struct packed {
      logic              action;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [COST_W-1:0] edge_cost;
      logic              last_edge;
   } req_word_type;

   // result word
   typedef struct packed {
      logic              taken;
      logic [SLOT_W-1:0] tree_slot;
      logic [COST_W-1:0] kept_cost;
      logic              run_done;
   } rsp_word_type;

   // action codes
   localparam logic ACT_EDGE  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UP,
      ST_GRAND
   } state_type;

   // endpoint lies inside the forest
   function automatic logic node_ok(input logic [NODE_W-1:0] node);
      node_ok = (32'(node) < NODE_COUNT);
   endfunction

endpackage

[src/kuf_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
module kuf_ram #(
   parameter  int WIDTH  = 10,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/kruskal_union_find_edge_filter.sv]
// Top level of the Kruskal edge filter: union-find forest in a parent RAM.
//
//   channel   ports                        handshake
//   -------   --------------------------   ---------------------------------
//   request   start, busy, req_word        taken when start && !busy
//   result    rsp_strobe, rsp_word         one-cycle strobe, cannot stall
//
// An edge keeps busy high while it walks from node_a and then from node_b to
// their roots by double jumps; the next edge may start in the cycle its result
// is shown. Every jump costs two reads of the single parent RAM port. Reset and
// each clear command run a sweep that writes one parent entry a cycle over all
// NODE_COUNT entries, with busy high throughout; a clear command gets its result
// when the sweep ends. The receiver cannot stall.
module kruskal_union_find_edge_filter
   import kuf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_COUNT - 1);

   state_type         state_ff,    state_in;
   req_word_type      req_ff,      req_in;
   logic [ADDR_W-1:0] cur_ff,      cur_in;
   logic [ADDR_W-1:0] root_a_ff,   root_a_in;
   logic              walk_b_ff,   walk_b_in;
   logic [ADDR_W-1:0] clr_ff,      clr_in;
   logic              clr_rsp_ff,  clr_rsp_in;
   logic [SLOT_W-1:0] kept_ff,     kept_in;
   logic              strobe_ff,   strobe_in;
   rsp_word_type      rsp_ff,      rsp_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ADDR_W-1:0] ram_rdata;

   // parent table
   kuf_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (NODE_COUNT)
   ) u_parent (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         kept_ff    <= '0;
         strobe_ff  <= 1'b0;
         walk_b_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         kept_ff    <= kept_in;
         strobe_ff  <= strobe_in;
         walk_b_ff  <= walk_b_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      cur_ff    <= cur_in;
      root_a_ff <= root_a_in;
      rsp_ff    <= rsp_in;
   end

   // next state, RAM access and result
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      cur_in     = cur_ff;
      root_a_in  = root_a_ff;
      walk_b_in  = walk_b_ff;
      clr_in     = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      kept_in    = kept_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      ram_we     = 1'b0;
      ram_waddr  = root_a_ff;
      ram_wdata  = cur_ff;
      ram_re     = 1'b0;
      ram_raddr  = cur_ff;

      case (state_ff)
         // sweep: every entry points at itself
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in   = ST_IDLE;
               clr_in     = '0;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  strobe_in       = 1'b1;
                  rsp_in.taken     = 1'b0;
                  rsp_in.tree_slot = '0;
                  rsp_in.kept_cost = '0;
                  rsp_in.run_done  = req_ff.last_edge;
               end
            end
         end

         ST_IDLE: begin
            if (start) begin
               req_in = req_word;
               if (req_word.action == ACT_CLEAR) begin
                  kept_in    = '0;
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else if (!(node_ok(req_word.node_a) && node_ok(req_word.node_b))) begin
                  // endpoint outside the forest: ignored
                  strobe_in        = 1'b1;
                  rsp_in.taken     = 1'b0;
                  rsp_in.tree_slot = '0;
                  rsp_in.kept_cost = '0;
                  rsp_in.run_done  = req_word.last_edge;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ADDR_W'(req_word.node_a);
                  cur_in    = ADDR_W'(req_word.node_a);
                  walk_b_in = 1'b0;
                  state_in  = ST_UP;
               end
            end
         end

         // rd_data holds parent of cur
         ST_UP: begin
            if (ram_rdata == cur_ff) begin
               if (!walk_b_ff) begin
                  // root of node_a found, start walk from node_b
                  root_a_in = cur_ff;
                  cur_in    = ADDR_W'(req_ff.node_b);
                  ram_re    = 1'b1;
                  ram_raddr = ADDR_W'(req_ff.node_b);
                  walk_b_in = 1'b1;
               end else begin
                  state_in        = ST_IDLE;
                  strobe_in       = 1'b1;
                  rsp_in.run_done = req_ff.last_edge;
                  if (root_a_ff != cur_ff) begin
                     // link root of a under root of b
                     ram_we           = 1'b1;
                     rsp_in.taken     = 1'b1;
                     rsp_in.tree_slot = kept_ff;
                     rsp_in.kept_cost = req_ff.edge_cost;
                     kept_in          = kept_ff + SLOT_W'(1);
                  end else begin
                     rsp_in.taken     = 1'b0;
                     rsp_in.tree_slot = '0;
                     rsp_in.kept_cost = '0;
                  end
               end
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ram_rdata;
               state_in  = ST_GRAND;
            end
         end

         // rd_data holds grandparent: jump there
         ST_GRAND: begin
            cur_in    = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = ram_rdata;
            state_in  = ST_UP;
         end

         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

[src/kuf_checker.sv]
// Port-level checks for the Kruskal edge filter, bound to the top level.
module kuf_checker
   import kuf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         rsp_strobe,
   input rsp_word_type rsp_word
);

   // a dropped edge carries no slot and no cost
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.taken |-> rsp_word.tree_slot == '0 && rsp_word.kept_cost == '0)
      else $error("dropped edge with nonzero slot or cost");

   // the forest sweep runs right after reset
   a_reset_sweep: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("not busy right after reset");

   // a clear command starts the sweep
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_word.action == ACT_CLEAR |=> busy && !rsp_strobe)
      else $error("clear command did not start the sweep");

   // an edge either starts a walk or is answered at once
   a_edge_walk: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_word.action == ACT_EDGE |=> busy || rsp_strobe)
      else $error("edge neither walked nor answered");

endmodule

bind kruskal_union_find_edge_filter kuf_checker u_kuf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

[bench/kuf_checker.sv]
// Checker for the Kruskal edge filter: mirrors the forest and compares each result word.
`timescale 1ns / 100ps

module kuf_scoreboard
   import kuf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_word_type req_word,
   input  logic         rsp_strobe,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           pending
);

   // private copy of the union-find forest and the slot counter
   logic [NODE_W-1:0] forest [NODE_COUNT];
   logic [SLOT_W-1:0] slot_next;
   rsp_word_type      expected_words [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // every node back to its own root, slot count to zero
   function automatic void reset_forest();
      for (int i = 0; i < NODE_COUNT; i++)
         forest[i] = NODE_W'(i);
      slot_next = '0;
   endfunction

   // root walk, two links per step, table left untouched
   function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] up;
      logic [NODE_W-1:0] cur;
      cur = node;
      for (int steps = 0; steps < NODE_COUNT; steps++) begin
         up = forest[cur];
         if (up == cur)
            break;
         cur = forest[up];
      end
      return cur;
   endfunction

   // applies one accepted word to the forest, returns the result word it causes
   function automatic rsp_word_type forest_outcome(input req_word_type w);
      rsp_word_type      r;
      logic [NODE_W-1:0] root_a;
      logic [NODE_W-1:0] root_b;
      r          = '0;
      r.run_done = w.last_edge;
      if (w.action == ACT_CLEAR) begin
         reset_forest();
         return r;
      end
      // endpoints outside the forest are ignored
      if (32'(w.node_a) >= NODE_COUNT || 32'(w.node_b) >= NODE_COUNT)
         return r;
      root_a = find_root(w.node_a);
      root_b = find_root(w.node_b);
      if (root_a != root_b) begin
         forest[root_a] = root_b;
         r.taken        = 1'b1;
         r.tree_slot    = slot_next;
         r.kept_cost    = w.edge_cost;
         slot_next      = slot_next + SLOT_W'(1);
      end
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   // result first: a new word may be taken on the edge that ends the previous result
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         reset_forest();
         expected_words.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               $display("%0t: result word with none expected: expected nothing, actual %h",
                        $time, rsp_word);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("taken",     32'(want.taken),     32'(rsp_word.taken));
               check_field("tree_slot", 32'(want.tree_slot), 32'(rsp_word.tree_slot));
               check_field("kept_cost", 32'(want.kept_cost), 32'(rsp_word.kept_cost));
               check_field("run_done",  32'(want.run_done),  32'(rsp_word.run_done));
            end
         end
         if (start && !busy)
            expected_words.push_back(forest_outcome(req_word));
      end
      pending <= expected_words.size();
   end

endmodule

[bench/tb_top.sv]
// Testbench top: edge stimulus, stall watchdog and verdict for the Kruskal edge filter.
`timescale 1ns / 100ps

module tb_top;
   import kuf_pkg::*;

   // longest quiet stretch: clear sweep plus deep walks and sender gaps, several times over
   localparam int STALL_LIMIT   = 6000;
   localparam int RANDOM_WORDS  = 550;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_word_type req_word = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   int           fail_count;
   int           pending;
   int           quiet_cycles = 0;
   int           words_sent   = 0;
   bit           burst_mode   = 1'b0;

   always #5 clock = ~clock;

   kruskal_union_find_edge_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   kuf_scoreboard u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic req_word_type make_word(input logic act, input int a, input int b,
                                              input int cost, input logic last);
      req_word_type w;
      w.action    = act;
      w.node_a    = NODE_W'(a);
      w.node_b    = NODE_W'(b);
      w.edge_cost = COST_W'(cost);
      w.last_edge = last;
      return w;
   endfunction

   // random gap, then hold start until the word is taken
   task automatic send_word(input req_word_type w);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   // hold off until every expected result has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // one graph: usually a clear, then ascending-cost edges over a small node window
   task automatic send_graph();
      int n;
      int base;
      int edges;
      int cost;
      logic last;
      n     = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(2, 20);
      base  = $urandom_range(0, NODE_COUNT - n);
      edges = $urandom_range(n - 1, 3 * n);
      cost  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 65535);
      burst_mode = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 5) != 0)
         send_word(make_word(ACT_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 65535), 1'b0));
      for (int e = 0; e < edges; e++) begin
         cost = cost + $urandom_range(0, 500);
         if (cost > 65535)
            cost = 65535;
         // stray end markers make a broken sequence now and then
         last = (e == edges - 1) || ($urandom_range(0, 29) == 0);
         send_word(make_word(ACT_EDGE, base + $urandom_range(0, n - 1),
                             base + $urandom_range(0, n - 1), cost, last));
      end
      burst_mode = 1'b0;
   endtask

   // fully random words over the whole field ranges, rare clears
   task automatic send_noise();
      logic act;
      act = ($urandom_range(0, 39) == 0) ? ACT_CLEAR : ACT_EDGE;
      send_word(make_word(act, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 65535), 1'($urandom_range(0, 1))));
   endtask

   // watchdog: cycles with neither a word taken nor a result shown
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: far endpoints, repeat edge, self loop
      send_word(make_word(ACT_EDGE, 0, 1023, 0, 1'b0));
      send_word(make_word(ACT_EDGE, 1023, 0, 1, 1'b0));
      send_word(make_word(ACT_EDGE, 5, 5, 2, 1'b0));
      // chain 1-2-3-4-5-6 so walks need several double jumps
      for (int k = 1; k <= 5; k++)
         send_word(make_word(ACT_EDGE, k, k + 1, 2 + k, 1'b0));
      send_word(make_word(ACT_EDGE, 1, 6, 8, 1'b0));
      send_word(make_word(ACT_EDGE, 6, 1, 9, 1'b0));
      send_word(make_word(ACT_EDGE, 2, 5, 10, 1'b0));
      send_word(make_word(ACT_EDGE, 1, 7, 11, 1'b0));
      send_word(make_word(ACT_EDGE, 1023, 512, 65535, 1'b1));
      // clear, then the same edge is taken again from slot zero
      send_word(make_word(ACT_CLEAR, 0, 0, 0, 1'b0));
      send_word(make_word(ACT_EDGE, 0, 1023, 16'h8001, 1'b0));
      send_word(make_word(ACT_EDGE, 1023, 0, 16'h8002, 1'b0));
      // clear carrying end marker and busy fields, then alternating bit patterns
      send_word(make_word(ACT_CLEAR, 1023, 1023, 65535, 1'b1));
      send_word(make_word(ACT_EDGE, 682, 341, 16'h5555, 1'b0));
      send_word(make_word(ACT_EDGE, 341, 682, 16'hAAAA, 1'b1));
      wait_drained();

      // random: mostly well-formed graphs, some noise, occasional full drain
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_mode = ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 8)) send_noise();
            burst_mode = 1'b0;
         end else begin
            send_graph();
         end
         if ($urandom_range(0, 4) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
